@@ design/d8fd_pkg.sv @@
// d8fd_pkg: types and constants shared by the D8 flow-direction block
// no dependencies; imported by d8fd_select and d8_flow_direction
`default_nettype none

package d8fd_pkg;

   // elevation sample, signed Q24.8
   typedef logic signed [31:0] elev_type;

   // flow code, signed 5 bits
   typedef logic signed [4:0] code_type;

   // configuration register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_NODATA_VALUE = 2'd2;

   // reset values of the configuration registers
   localparam int        IMAGE_SIZE_RESET = 4096;
   localparam int        IMAGE_SIZE_MIN   = 3;
   localparam elev_type  NODATA_RESET     = -32'sd256;

   // D8 codes, clockwise from north-west
   localparam code_type CODE_NW   = 5'sd1;
   localparam code_type CODE_N    = 5'sd2;
   localparam code_type CODE_NE   = 5'sd3;
   localparam code_type CODE_E    = 5'sd4;
   localparam code_type CODE_SE   = 5'sd5;
   localparam code_type CODE_S    = 5'sd6;
   localparam code_type CODE_SW   = 5'sd7;
   localparam code_type CODE_W    = 5'sd8;
   localparam code_type CODE_NONE = -5'sd1;

   // window position of the centre, neighbours in scan order and their codes
   localparam int       CENTRE_POS  = 4;
   localparam int       NB_COUNT    = 8;
   localparam int       NB_POS  [NB_COUNT] = '{0, 1, 2, 3, 5, 6, 7, 8};
   localparam code_type NB_CODE [NB_COUNT] =
      '{CODE_NW, CODE_N, CODE_NE, CODE_W, CODE_E, CODE_SW, CODE_S, CODE_SE};

   // result queue depth, covers the two pipeline stages ahead of it
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   // position and flags that travel with each word down the pipeline
   typedef struct packed {
      logic        interior;
      logic        frame_last;
      logic [11:0] out_column;
      logic [11:0] out_row;
   } tag_type;

   // one finished result word
   typedef struct packed {
      code_type    flow_code;
      logic        interior;
      logic [11:0] out_column;
      logic [11:0] out_row;
      logic        frame_last;
   } result_type;

   // neighbour candidate in the minimum search
   typedef struct packed {
      logic     valid;
      elev_type value;
      code_type code;
   } cand_type;

endpackage

`default_nettype wire

@@ design/d8_flow_direction.sv @@
// d8_flow_direction: streaming D8 flow direction over a raster of elevations
// depends on d8fd_pkg, d8fd_ram, d8fd_select
//
//   channel   direction  ports                       handshake
//   req_      in         req_elevation               req_valid / req_stall
//   rsp_      out        rsp_flow_code ... frame_last rsp_valid / rsp_stall
//   csr_      in         csr_index, csr_wdata        csr_valid / csr_ready
//
// One word per cycle sustained while req_stall stays low; after its sample a result passes
// the line store read, the window shift and the code select into a four-entry result queue.
// Throughput is set by the single line-store RAM port pair, one access per word.
// Reset (synchronous) clears the counters, pipeline and queue; line stores
// are not cleared. req_stall rises while the queue and the stages ahead of it
// hold four words, so a stalled result side never loses a word.
`default_nettype none

module d8_flow_direction
   import d8fd_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // sample input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire elev_type    req_elevation,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output code_type         rsp_flow_code,
   output logic             rsp_interior,
   output logic [11:0]      rsp_out_column,
   output logic [11:0]      rsp_out_row,
   output logic             rsp_frame_last,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;
   localparam int HW = (RW + 1 > 13) ? RW + 1 : 13;
   localparam int OCW = (CW > 12) ? CW : 12;
   localparam int ORW = (RW > 12) ? RW : 12;
   localparam int WIDTH_RESET  = (IMAGE_SIZE_RESET > MAX_WIDTH)  ? MAX_WIDTH  : IMAGE_SIZE_RESET;
   localparam int HEIGHT_RESET = (IMAGE_SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_SIZE_RESET;

   // configuration, sizes stored already clamped
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   elev_type      nodata_ff, nodata_in;

   // raster position of the next sample
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // stage 1: line store read in flight
   logic          s1_valid_ff, s1_valid_in;
   elev_type      s1_elev_ff;
   logic [CW-1:0] s1_col_ff;
   tag_type       s1_tag_ff, s1_tag_in;

   // stage 2: window holds the word's neighbourhood
   logic          s2_valid_ff;
   tag_type       s2_tag_ff;
   elev_type      win_ff [9];

   // result queue
   result_type           queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic [QUEUE_CW-1:0]  occupancy;

   logic          accept;
   logic          pop;
   logic [63:0]   store_rd;
   code_type      sel_code;
   logic [WW-1:0] col_next;
   logic [HW-1:0] row_next;
   logic          col_wrap, row_wrap;
   logic [WW-1:0] wr_size_w;
   logic [HW-1:0] wr_size_h;
   logic [OCW-1:0] col_prev;
   logic [ORW-1:0] row_prev;

   // handshakes
   assign csr_ready = 1'b1;
   assign occupancy = count_ff + QUEUE_CW'(s1_valid_ff) + QUEUE_CW'(s2_valid_ff);
   assign req_stall = (occupancy >= QUEUE_CW'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   // clamp written sizes to the supported range
   always_comb begin
      wr_size_w = WW'(csr_wdata[12:0]);
      if (wr_size_w < WW'(IMAGE_SIZE_MIN)) begin
         wr_size_w = WW'(IMAGE_SIZE_MIN);
      end else if (wr_size_w > WW'(MAX_WIDTH)) begin
         wr_size_w = WW'(MAX_WIDTH);
      end
      wr_size_h = HW'(csr_wdata[12:0]);
      if (wr_size_h < HW'(IMAGE_SIZE_MIN)) begin
         wr_size_h = HW'(IMAGE_SIZE_MIN);
      end else if (wr_size_h > HW'(MAX_HEIGHT)) begin
         wr_size_h = HW'(MAX_HEIGHT);
      end
   end

   // register writes, unknown indexes ignored
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      nodata_in = nodata_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = wr_size_w;
            REG_IMAGE_HEIGHT: height_in = wr_size_h;
            REG_NODATA_VALUE: nodata_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // position counters and the tag of the accepted word
   always_comb begin
      col_next = WW'(col_ff) + WW'(1);
      row_next = HW'(row_ff) + HW'(1);
      col_wrap = (col_next >= width_ff);
      row_wrap = (row_next >= height_ff);
      col_prev = OCW'(col_ff) - OCW'(1);
      row_prev = ORW'(row_ff) - ORW'(1);

      s1_tag_in.interior   = (WW'(col_ff) >= WW'(2)) && (HW'(row_ff) >= HW'(2))
                             && (WW'(col_ff) < width_ff) && (HW'(row_ff) < height_ff);
      s1_tag_in.frame_last = col_wrap && row_wrap;
      s1_tag_in.out_column = col_prev[11:0];
      s1_tag_in.out_row    = row_prev[11:0];

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : RW'(row_next);
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   assign s1_valid_in = accept;

   // queue fill level
   always_comb begin
      count_in = count_ff;
      if (s2_valid_ff && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (!s2_valid_ff && pop) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(WIDTH_RESET);
         height_ff   <= HW'(HEIGHT_RESET);
         nodata_ff   <= NODATA_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         nodata_ff   <= nodata_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         count_ff    <= count_in;
         if (s2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_elev_ff <= req_elevation;
         s1_col_ff  <= col_ff;
         s1_tag_ff  <= s1_tag_in;
      end
   end

   // line stores: upper half is two rows back, lower half one row back
   d8fd_ram #(
      .WIDTH (64),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({store_rd[31:0], s1_elev_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (store_rd)
   );

   // window shift, new column from the stores and the sample
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= store_rd[63:32];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= store_rd[31:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= s1_elev_ff;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   d8fd_select u_select (
      .window    (win_ff),
      .nodata    (nodata_ff),
      .interior  (s2_tag_ff.interior),
      .flow_code (sel_code)
   );

   // result queue entries
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         queue_ff[wr_ptr_ff].flow_code  <= sel_code;
         queue_ff[wr_ptr_ff].interior   <= s2_tag_ff.interior;
         queue_ff[wr_ptr_ff].out_column <= s2_tag_ff.out_column;
         queue_ff[wr_ptr_ff].out_row    <= s2_tag_ff.out_row;
         queue_ff[wr_ptr_ff].frame_last <= s2_tag_ff.frame_last;
      end
   end

   // result outputs
   assign rsp_flow_code  = queue_ff[rd_ptr_ff].flow_code;
   assign rsp_interior   = queue_ff[rd_ptr_ff].interior;
   assign rsp_out_column = queue_ff[rd_ptr_ff].out_column;
   assign rsp_out_row    = queue_ff[rd_ptr_ff].out_row;
   assign rsp_frame_last = queue_ff[rd_ptr_ff].frame_last;

endmodule

`default_nettype wire

@@ design/d8fd_ram.sv @@
// d8fd_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies; used for the line stores of d8_flow_direction
`default_nettype none

module d8fd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/d8fd_select.sv @@
// d8fd_select: picks the D8 code from a 3x3 elevation window
// depends on d8fd_pkg
`default_nettype none

module d8fd_select
   import d8fd_pkg::*;
(
   input  wire elev_type window [9],
   input  wire elev_type nodata,
   input  wire logic     interior,
   output code_type      flow_code
);

   // later candidate wins only if valid and strictly lower, so ties keep scan order
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type res;
      res = a;
      if (b.valid && (!a.valid || (b.value < a.value))) begin
         res = b;
      end
      return res;
   endfunction

   cand_type lvl0 [NB_COUNT];
   cand_type lvl1 [4];
   cand_type lvl2 [2];
   cand_type best;

   // neighbours in scan order, nodata ones drop out
   always_comb begin
      for (int i = 0; i < NB_COUNT; i++) begin
         lvl0[i].valid = (window[NB_POS[i]] != nodata);
         lvl0[i].value = window[NB_POS[i]];
         lvl0[i].code  = NB_CODE[i];
      end
   end

   // three-level tournament for the lowest neighbour
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
      end
      best = pick(lvl2[0], lvl2[1]);
   end

   // lowest neighbour must sit below a valid interior centre
   always_comb begin
      flow_code = CODE_NONE;
      if (interior && (window[CENTRE_POS] != nodata) && best.valid
          && (best.value < window[CENTRE_POS])) begin
         flow_code = best.code;
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for the d8_flow_direction streaming block
// depends on d8fd_pkg and the design sources; predicts every result word and checks it

module tb;
   import d8fd_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int LINE_MAX       = 4096;
   localparam int ROWS_MAX       = 4096;
   localparam int DRAIN_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_SAMPLES = 250;
   localparam int WIN_CENTRE     = 4;
   // columns whose store entries get defined before the random frames run
   localparam int FILL_WIDTH     = 48;
   localparam int WIDE_SAMPLES   = 32;

   // index outside the register map, writes to it must be dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam elev_type ELEV_MIN = 32'h8000_0000;
   localparam elev_type ELEV_MAX = 32'h7fff_ffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   elev_type    req_elevation = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   code_type    rsp_flow_code;
   logic        rsp_interior;
   logic [11:0] rsp_out_column;
   logic [11:0] rsp_out_row;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow of the block: line stores, window, raster position and settings
   elev_type    upper_line  [LINE_MAX];
   elev_type    middle_line [LINE_MAX];
   elev_type    pixel_window [9];
   int          col_at;
   int          row_at;
   logic [12:0] width_reg;
   logic [12:0] height_reg;
   elev_type    nodata_reg;

   result_type  flow_expected [$];

   int          idle_pct = 0;
   int          hold_request = 0;
   int          samples_sent = 0;
   int          results_checked = 0;
   int          interior_seen = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   logic [8:0]  codes_seen = '0;

   d8_flow_direction u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elevation  (req_elevation),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_flow_code  (rsp_flow_code),
      .rsp_interior   (rsp_interior),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // size registers saturate into the supported range
   function automatic int clamped_size(input logic [12:0] size, input int hi);
      if (size < 13'(IMAGE_SIZE_MIN)) return IMAGE_SIZE_MIN;
      if (int'(size) > hi) return hi;
      return int'(size);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // small values give ties and plateaus, the rest cover the full range
   function automatic elev_type pick_elevation();
      case ($urandom_range(11))
         0:       return nodata_reg;
         1, 2:    return $urandom();
         3:       return ($urandom_range(1) != 0) ? ELEV_MAX : ELEV_MIN;
         default: return elev_type'($urandom_range(16)) - 8;
      endcase
   endfunction

   // one sample through the shadow: window shift, lowest-neighbour search, position
   task automatic predict_flow(input elev_type value, output result_type res);
      int       w;
      int       h;
      int       c;
      int       r;
      int       i;
      int       p;
      logic     inner;
      elev_type lowest;
      elev_type nb;
      code_type code;
      code_type cd;
      w = clamped_size(width_reg, LINE_MAX);
      h = clamped_size(height_reg, ROWS_MAX);
      c = col_at;
      r = row_at;

      // shift left, new column enters on the right from the stores and the sample
      for (i = 0; i < 3; i++) begin
         pixel_window[i * 3]     = pixel_window[i * 3 + 1];
         pixel_window[i * 3 + 1] = pixel_window[i * 3 + 2];
      end
      pixel_window[2] = upper_line[c];
      pixel_window[5] = middle_line[c];
      pixel_window[8] = value;
      upper_line[c]   = middle_line[c];
      middle_line[c]  = value;

      // scan NW,N,NE,W,E,SW,S,SE; strictly lower wins so the first of a tie stays
      inner = (r >= 2) && (c >= 2) && (r < h) && (c < w);
      code  = CODE_NONE;
      if (inner && pixel_window[WIN_CENTRE] != nodata_reg) begin
         lowest = pixel_window[WIN_CENTRE];
         for (i = 0; i < 8; i++) begin
            case (i)
               0:       begin p = 0; cd = CODE_NW; end
               1:       begin p = 1; cd = CODE_N;  end
               2:       begin p = 2; cd = CODE_NE; end
               3:       begin p = 3; cd = CODE_W;  end
               4:       begin p = 5; cd = CODE_E;  end
               5:       begin p = 6; cd = CODE_SW; end
               6:       begin p = 7; cd = CODE_S;  end
               default: begin p = 8; cd = CODE_SE; end
            endcase
            nb = pixel_window[p];
            if (nb != nodata_reg && nb < lowest) begin
               lowest = nb;
               code   = cd;
            end
         end
      end

      res.flow_code  = code;
      res.interior   = inner;
      res.out_column = 12'(c - 1);
      res.out_row    = 12'(r - 1);
      res.frame_last = (c + 1 >= w) && (r + 1 >= h);

      // counters past a shrunken size wrap on their next advance
      if (c + 1 >= w) begin
         col_at = 0;
         row_at = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_at = c + 1;
      end
   endtask

   // offer one sample, possibly after a gap, and wait until it is taken
   task automatic send_elevation(input elev_type value);
      int         gap;
      result_type want;
      gap = ($urandom_range(99) < idle_pct) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_elevation <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_flow(value, want);
      flow_expected.push_back(want);
      samples_sent++;
   endtask

   task automatic send_samples(input int count);
      for (int i = 0; i < count; i++) send_elevation(pick_elevation());
   endtask

   // drop valid and let every outstanding word come out
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (flow_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         REG_IMAGE_WIDTH:  width_reg  = data[12:0];
         REG_IMAGE_HEIGHT: height_reg = data[12:0];
         REG_NODATA_VALUE: nodata_reg = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // first row at reset settings: positions wrap to 4095, nothing interior
   task automatic test_reset_defaults();
      idle_pct = 0;
      send_elevation(ELEV_MIN);
      send_elevation(ELEV_MAX);
      send_elevation(NODATA_RESET);
      send_elevation('0);
      drain_results();
   endtask

   // shrink to 3x3 while the column counter sits past the new width
   task automatic test_resize_mid_frame();
      write_setting(REG_IMAGE_WIDTH, 32'd3);
      write_setting(REG_IMAGE_HEIGHT, 32'd3);
      write_setting(REG_UNUSED, 32'd5);
      send_samples(7);
      drain_results();
   endtask

   // 5x3 raster with nodata at the most negative value:
   // left centre skips a nodata corner and breaks an N/W tie toward N,
   // middle centre is nodata, right centre sees only equal, higher or nodata
   task automatic test_window_cases();
      elev_type grid [15];
      write_setting(REG_IMAGE_WIDTH, 32'd5);
      write_setting(REG_IMAGE_HEIGHT, 32'd3);
      write_setting(REG_NODATA_VALUE, ELEV_MIN);
      grid = '{ELEV_MIN, -7, ELEV_MAX, -100, ELEV_MAX,
               -7, 0, ELEV_MIN, -100, 5,
               -3, 0, 1, -99, ELEV_MAX};
      for (int i = 0; i < 15; i++) send_elevation(grid[i]);
      drain_results();
   endtask

   // undersized height saturates to three rows; the full frame fills both stores
   // over every column the random frames reach, then a short run at oversized width
   task automatic test_widest_raster();
      idle_pct = 5;
      write_setting(REG_IMAGE_WIDTH, 32'(FILL_WIDTH));
      write_setting(REG_IMAGE_HEIGHT, 32'd2);
      write_setting(REG_NODATA_VALUE, 32'd3);
      send_samples(3 * FILL_WIDTH);
      drain_results();
      write_setting(REG_IMAGE_WIDTH, 32'd8191);
      send_samples(WIDE_SAMPLES);
      drain_results();
   endtask

   // first rows at the tallest height, then a cut mid-frame so the row counter is past the height
   task automatic test_height_extremes();
      idle_pct = 20;
      write_setting(REG_IMAGE_WIDTH, 32'd3);
      write_setting(REG_IMAGE_HEIGHT, 32'(ROWS_MAX));
      write_setting(REG_NODATA_VALUE, NODATA_RESET);
      send_samples(3 * 30);
      drain_results();
      write_setting(REG_IMAGE_HEIGHT, 32'd3);
      send_samples(3 + 9);
      drain_results();
   endtask

   // result side holds off long enough for the block to stall its input
   task automatic test_backpressure();
      idle_pct     = 0;
      hold_request = HOLD_CYCLES;
      write_setting(REG_IMAGE_WIDTH, 32'd6);
      write_setting(REG_IMAGE_HEIGHT, 32'd4);
      send_samples(48);
      drain_results();
   endtask

   // random small frames with random settings; some frames are cut short
   task automatic test_random_frames();
      int       sent;
      int       cols;
      int       rows_n;
      int       count;
      elev_type nodata;
      sent = 0;
      while (sent < RANDOM_SAMPLES) begin
         idle_pct = ($urandom_range(3) == 0) ? 0 : 35;
         case ($urandom_range(19))
            0:       cols = $urandom_range(2);
            1, 2:    cols = $urandom_range(11, 40);
            default: cols = $urandom_range(3, 10);
         endcase
         rows_n = ($urandom_range(19) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
         write_setting(REG_IMAGE_WIDTH, ($urandom() & 32'hffff_e000) | 32'(cols));
         write_setting(REG_IMAGE_HEIGHT, ($urandom() & 32'hffff_e000) | 32'(rows_n));
         if ($urandom_range(1) == 0) begin
            case ($urandom_range(4))
               0:       nodata = NODATA_RESET;
               1:       nodata = ELEV_MIN;
               2:       nodata = ELEV_MAX;
               3:       nodata = $urandom();
               default: nodata = elev_type'($urandom_range(16)) - 8;
            endcase
            write_setting(REG_NODATA_VALUE, nodata);
         end
         count = clamped_size(width_reg, LINE_MAX) * clamped_size(height_reg, ROWS_MAX);
         if ($urandom_range(6) == 0) count = $urandom_range(1, count - 1);
         send_samples(count);
         sent += count;
         drain_results();
      end
   endtask

   // result side: random stalls, or a long hold-off when a test asks for one
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && $urandom_range(99) < idle_pct) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         results_checked++;
         if (rsp_interior) interior_seen++;
         if (rsp_flow_code == CODE_NONE) codes_seen[0] = 1'b1;
         else codes_seen[rsp_flow_code[3:0]] = 1'b1;
         if (flow_expected.size() == 0) begin
            $error("result word with nothing expected: code %0d row %0d column %0d",
                   rsp_flow_code, rsp_out_row, rsp_out_column);
            fail_count++;
         end else begin
            want = flow_expected.pop_front();
            if (rsp_flow_code !== want.flow_code) begin
               $error("flow_code: expected %0d, got %0d", want.flow_code, rsp_flow_code);
               fail_count++;
            end
            if (rsp_interior !== want.interior) begin
               $error("interior: expected %0d, got %0d", want.interior, rsp_interior);
               fail_count++;
            end
            if (rsp_out_column !== want.out_column) begin
               $error("out_column: expected %0d, got %0d", want.out_column, rsp_out_column);
               fail_count++;
            end
            if (rsp_out_row !== want.out_row) begin
               $error("out_row: expected %0d, got %0d", want.out_row, rsp_out_row);
               fail_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0d, got %0d", want.frame_last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, flow_expected.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : run_tests
      // shadow starts from the reset settings with cleared stores and window
      width_reg  = 13'(IMAGE_SIZE_RESET);
      height_reg = 13'(IMAGE_SIZE_RESET);
      nodata_reg = NODATA_RESET;
      col_at     = 0;
      row_at     = 0;
      for (int i = 0; i < LINE_MAX; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) pixel_window[i] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_resize_mid_frame();
      test_window_cases();
      test_widest_raster();
      test_height_extremes();
      test_backpressure();
      test_random_frames();

      $display("covered %0d samples on rasters from 3 to %0d wide, %0d words checked, %0d interior",
               samples_sent, LINE_MAX, results_checked, interior_seen);
      $display("flow codes seen (W down to NW, then none): %b", codes_seen);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
